/* rtl/object_record_name_rewriter_unit_macros.svh */
// Assertion helpers shared by the rewriter RTL.
// Both expect clk_i and rst_ni in scope.
`ifndef OBJECT_RECORD_NAME_REWRITER_UNIT_MACROS_SVH
`define OBJECT_RECORD_NAME_REWRITER_UNIT_MACROS_SVH

// Same-cycle implication.
`define ORN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ORN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/orn_pkg.sv */
package orn_pkg;

  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  localparam logic [7:0] NAME_LIST_KIND = 8'h96;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_END   = 2'd1,
    OP_DRAIN = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_BYTE       = 3'd0,
    ST_CLEAN_END  = 3'd1,
    ST_SHORT_LEN  = 3'd2,
    ST_SHORT_DATA = 3'd3,
    ST_SHORT_SUM  = 3'd4,
    ST_OVERFLOW   = 3'd5,
    ST_BUSY_DROP  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    REG_SEARCH_LEN   = 3'd0,
    REG_SEARCH_LOW   = 3'd1,
    REG_SEARCH_HIGH  = 3'd2,
    REG_REPLACE_LEN  = 3'd3,
    REG_REPLACE_LOW  = 3'd4,
    REG_REPLACE_HIGH = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] in_byte;
  } orn_req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        record_end;
    logic [2:0]  status;
    logic [15:0] record_count;
    logic [15:0] replace_count;
  } orn_res_t;

  // Configuration as seen by the core; rlen is already cut to the name limit.
  typedef struct packed {
    logic [4:0]  search_len;
    logic        search_ok;
    logic [63:0] search_lo;
    logic [63:0] search_hi;
    logic [4:0]  rlen;
    logic [63:0] replace_lo;
    logic [63:0] replace_hi;
    logic [15:0] len_corr;
    logic [7:0]  chk_corr;
  } orn_cfg_t;

  // Byte idx of a 16-byte name held as two 64-bit words; zero beyond.
  function automatic logic [7:0] name_byte(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [4:0] idx);
    logic [7:0] b;
    b = '0;
    if (idx < 5'd8) begin
      b = lo[{idx[2:0], 3'b000} +: 8];
    end else if (idx < 5'd16) begin
      b = hi[{idx[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

/* rtl/orn_cfg_regs.sv */
module orn_cfg_regs #(
  parameter int unsigned NAME_BYTES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [orn_pkg::PADDR_W-1:0]   paddr,
  input  logic [orn_pkg::PDATA_W-1:0]   pwdata,
  output logic [orn_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output orn_pkg::orn_cfg_t             cfg_o
);
  import orn_pkg::*;

  logic [4:0]  slen_q;
  logic [63:0] s_lo_q, s_hi_q;
  logic [4:0]  rlen_raw_q;
  logic [63:0] r_lo_q, r_hi_q;
  logic [7:0]  chk_corr_q, chk_corr_d;

  logic        wr_en;
  cfg_reg_e    reg_idx;
  logic [4:0]  rlen;
  logic [7:0]  diff  [16];
  logic [7:0]  lvl1  [8];
  logic [7:0]  lvl2  [4];
  logic [7:0]  lvl3  [2];

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = cfg_reg_e'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slen_q     <= '0;
      s_lo_q     <= '0;
      s_hi_q     <= '0;
      rlen_raw_q <= '0;
      r_lo_q     <= '0;
      r_hi_q     <= '0;
      chk_corr_q <= '0;
    end else begin
      chk_corr_q <= chk_corr_d;
      if (wr_en) begin
        unique case (reg_idx)
          REG_SEARCH_LEN:   slen_q     <= pwdata[4:0];
          REG_SEARCH_LOW:   s_lo_q     <= pwdata;
          REG_SEARCH_HIGH:  s_hi_q     <= pwdata;
          REG_REPLACE_LEN:  rlen_raw_q <= pwdata[4:0];
          REG_REPLACE_LOW:  r_lo_q     <= pwdata;
          REG_REPLACE_HIGH: r_hi_q     <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEARCH_LEN:   prdata = {59'd0, slen_q};
      REG_SEARCH_LOW:   prdata = s_lo_q;
      REG_SEARCH_HIGH:  prdata = s_hi_q;
      REG_REPLACE_LEN:  prdata = {59'd0, rlen_raw_q};
      REG_REPLACE_LOW:  prdata = r_lo_q;
      REG_REPLACE_HIGH: prdata = r_hi_q;
      default:          prdata = '0;
    endcase
  end

  assign rlen = ({1'b0, rlen_raw_q} > 6'(NAME_BYTES)) ? 5'(NAME_BYTES) : rlen_raw_q;

  // Checksum delta of one replacement: length bytes plus name bytes, mod 256.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      diff[i] = ((5'(i) < rlen) ? name_byte(r_lo_q, r_hi_q, 5'(i)) : 8'd0)
              - ((5'(i) < slen_q) ? name_byte(s_lo_q, s_hi_q, 5'(i)) : 8'd0);
    end
    for (int i = 0; i < 8; i++) lvl1[i] = diff[2*i] + diff[2*i+1];
    for (int i = 0; i < 4; i++) lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
    for (int i = 0; i < 2; i++) lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
    chk_corr_d = {3'b000, rlen} - {3'b000, slen_q} + lvl3[0] + lvl3[1];
  end

  assign cfg_o.search_len = slen_q;
  assign cfg_o.search_ok  = ({1'b0, slen_q} <= 6'(NAME_BYTES));
  assign cfg_o.search_lo  = s_lo_q;
  assign cfg_o.search_hi  = s_hi_q;
  assign cfg_o.rlen       = rlen;
  assign cfg_o.replace_lo = r_lo_q;
  assign cfg_o.replace_hi = r_hi_q;
  assign cfg_o.len_corr   = {11'd0, rlen} - {11'd0, slen_q};
  assign cfg_o.chk_corr   = chk_corr_q;

endmodule

/* rtl/orn_core.sv */
`include "object_record_name_rewriter_unit_macros.svh"

module orn_core #(
  parameter int unsigned RECORD_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  orn_pkg::orn_req_t   request_i,
  input  orn_pkg::orn_cfg_t   cfg_i,
  output logic                result_valid_o,
  output orn_pkg::orn_res_t   result_o
);
  import orn_pkg::*;

  localparam int unsigned AW = $clog2(RECORD_BYTES);
  localparam int unsigned PW = $clog2(RECORD_BYTES + 1);
  localparam int unsigned DW = $clog2(RECORD_BYTES + 4);
  localparam logic [PW-1:0] RB_P = PW'(RECORD_BYTES);
  localparam logic [PW:0]   RB_X = (PW+1)'(RECORD_BYTES);
  localparam logic [16:0]   RB_L = 17'(RECORD_BYTES);

  typedef enum logic [5:0] {
    PH_TYPE   = 6'b000001,
    PH_LEN_LO = 6'b000010,
    PH_LEN_HI = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_SUM    = 6'b010000,
    PH_DRAIN  = 6'b100000
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [7:0]    kind_q, kind_d;
  logic [15:0]   len_q, len_d;
  logic [15:0]   data_left_q, data_left_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [AW-1:0] name_start_q, name_start_d;
  logic [7:0]    name_left_q, name_left_d;
  logic [4:0]    name_pos_q, name_pos_d;
  logic          match_q, match_d;
  logic [7:0]    chk_q, chk_d;
  logic [DW-1:0] drain_q, drain_d;
  logic          ovf_q, ovf_d;
  logic [15:0]   rec_cnt_q, rec_cnt_d;
  logic [15:0]   rep_cnt_q, rep_cnt_d;
  logic          sweep_q, sweep_d;
  logic [4:0]    sweep_idx_q, sweep_idx_d;

  logic          res_valid_q, res_valid_d;
  logic [7:0]    res_byte_q, res_byte_d;
  logic          res_end_q, res_end_d;
  status_e       res_status_q, res_status_d;
  logic          rd_sel_q, rd_sel_d;

  // record buffer, one write and one registered read per cycle
  logic [7:0]    store_q [RECORD_BYTES];
  logic [7:0]    rd_data_q;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data;

  logic [7:0]    b;
  logic [15:0]   len_hi_new, dl_new;
  logic          put_ovf, scan_match, scan_fin;
  logic [AW-1:0] scan_ns;
  logic [DW-1:0] drain_off;

  assign b          = request_i.in_byte;
  assign len_hi_new = {b, len_q[7:0]};
  assign dl_new     = (len_hi_new != 16'd0) ? len_hi_new - 16'd1 : 16'd0;
  assign drain_off  = drain_q - DW'(3);
  assign busy       = sweep_q;

  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    len_d        = len_q;
    data_left_d  = data_left_q;
    wp_d         = wp_q;
    name_start_d = name_start_q;
    name_left_d  = name_left_q;
    name_pos_d   = name_pos_q;
    match_d      = match_q;
    chk_d        = chk_q;
    drain_d      = drain_q;
    ovf_d        = ovf_q;
    rec_cnt_d    = rec_cnt_q;
    rep_cnt_d    = rep_cnt_q;
    sweep_d      = sweep_q;
    sweep_idx_d  = sweep_idx_q;
    res_valid_d  = 1'b0;
    res_byte_d   = '0;
    res_end_d    = 1'b0;
    res_status_d = ST_BYTE;
    rd_sel_d     = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    put_ovf      = ovf_q;
    scan_match   = 1'b0;
    scan_fin     = 1'b0;
    scan_ns      = name_start_q;

    if (sweep_q) begin
      // write length byte then replacement bytes over the matched name
      wr_en   = 1'b1;
      wr_addr = name_start_q + AW'(sweep_idx_q);
      wr_data = (sweep_idx_q == 5'd0) ? {3'b000, cfg_i.rlen}
              : name_byte(cfg_i.replace_lo, cfg_i.replace_hi, sweep_idx_q - 5'd1);
      if (sweep_idx_q == 5'd0) chk_d = chk_q + cfg_i.chk_corr;
      if (sweep_idx_q == cfg_i.rlen) begin
        sweep_d = 1'b0;
      end else begin
        sweep_idx_d = sweep_idx_q + 5'd1;
      end
    end else if (start) begin
      case (request_i.op)
        OP_BYTE: begin
          unique case (phase_q)
            PH_TYPE: begin
              if (rec_cnt_q != 16'hFFFF) rec_cnt_d = rec_cnt_q + 16'd1;
              kind_d      = b;
              len_d       = '0;
              wp_d        = '0;
              name_left_d = '0;
              name_pos_d  = '0;
              match_d     = 1'b0;
              chk_d       = '0;
              ovf_d       = 1'b0;
              phase_d     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              len_d   = {8'h00, b};
              phase_d = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              len_d       = len_hi_new;
              data_left_d = dl_new;
              if ({1'b0, dl_new} > RB_L) ovf_d = 1'b1;
              phase_d = (dl_new != 16'd0) ? PH_DATA : PH_SUM;
            end
            PH_DATA: begin
              data_left_d = data_left_q - 16'd1;
              if (!ovf_q) begin
                if (wp_q >= RB_P) begin
                  put_ovf = 1'b1;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = wp_q[AW-1:0];
                  wr_data = b;
                  wp_d    = wp_q + PW'(1);
                end
              end
              ovf_d = put_ovf;
              if (!put_ovf && kind_q == NAME_LIST_KIND) begin
                if (name_left_q == 8'd0) begin
                  // this byte is a name's length byte
                  scan_ns      = wp_q[AW-1:0];
                  name_start_d = scan_ns;
                  name_pos_d   = '0;
                  scan_match   = (b == {3'b000, cfg_i.search_len}) && cfg_i.search_ok;
                  name_left_d  = b;
                  scan_fin     = scan_match && (b == 8'd0);
                end else begin
                  scan_match = match_q;
                  if (match_q) begin
                    if (b != name_byte(cfg_i.search_lo, cfg_i.search_hi, name_pos_q)) begin
                      scan_match = 1'b0;
                    end
                    name_pos_d = name_pos_q + 5'd1;
                  end
                  name_left_d = name_left_q - 8'd1;
                  scan_fin    = scan_match && (name_left_q == 8'd1);
                end
                match_d = scan_match;
                if (scan_fin) begin
                  match_d = 1'b0;
                  if ((PW+1)'(scan_ns) + (PW+1)'(cfg_i.rlen) + (PW+1)'(1) > RB_X) begin
                    ovf_d = 1'b1;
                  end else begin
                    sweep_d     = 1'b1;
                    sweep_idx_d = '0;
                    wp_d        = PW'(scan_ns) + PW'(cfg_i.rlen) + PW'(1);
                    len_d       = len_q + cfg_i.len_corr;
                    if (rep_cnt_q != 16'hFFFF) rep_cnt_d = rep_cnt_q + 16'd1;
                  end
                end
              end
              if (data_left_q == 16'd1) phase_d = PH_SUM;
            end
            PH_SUM: begin
              chk_d = chk_q + b;
              if (ovf_q) begin
                ovf_d        = 1'b0;
                phase_d      = PH_TYPE;
                res_valid_d  = 1'b1;
                res_status_d = ST_OVERFLOW;
              end else begin
                drain_d = '0;
                phase_d = PH_DRAIN;
              end
            end
            PH_DRAIN: begin
              res_valid_d  = 1'b1;
              res_status_d = ST_BUSY_DROP;
            end
            default: ;
          endcase
        end
        OP_END: begin
          res_valid_d = 1'b1;
          unique case (phase_q) inside
            PH_LEN_LO, PH_LEN_HI: res_status_d = ST_SHORT_LEN;
            PH_DATA:              res_status_d = ST_SHORT_DATA;
            PH_SUM:               res_status_d = ST_SHORT_SUM;
            default:              res_status_d = ST_CLEAN_END;
          endcase
          if (phase_q != PH_DRAIN) begin
            phase_d     = PH_TYPE;
            ovf_d       = 1'b0;
            name_left_d = '0;
            match_d     = 1'b0;
          end
        end
        OP_DRAIN: begin
          if (phase_q == PH_DRAIN) begin
            drain_d     = drain_q + DW'(1);
            res_valid_d = 1'b1;
            if (drain_q == DW'(0)) begin
              res_byte_d = kind_q;
            end else if (drain_q == DW'(1)) begin
              res_byte_d = len_q[7:0];
            end else if (drain_q == DW'(2)) begin
              res_byte_d = len_q[15:8];
            end else if (drain_off < DW'(wp_q)) begin
              rd_en    = 1'b1;
              rd_addr  = drain_off[AW-1:0];
              rd_sel_d = 1'b1;
            end else begin
              res_byte_d = chk_q;
              res_end_d  = 1'b1;
              phase_d    = PH_TYPE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TYPE;
      kind_q       <= '0;
      len_q        <= '0;
      data_left_q  <= '0;
      wp_q         <= '0;
      name_start_q <= '0;
      name_left_q  <= '0;
      name_pos_q   <= '0;
      match_q      <= 1'b0;
      chk_q        <= '0;
      drain_q      <= '0;
      ovf_q        <= 1'b0;
      rec_cnt_q    <= '0;
      rep_cnt_q    <= '0;
      sweep_q      <= 1'b0;
      sweep_idx_q  <= '0;
      res_valid_q  <= 1'b0;
      res_byte_q   <= '0;
      res_end_q    <= 1'b0;
      res_status_q <= ST_BYTE;
      rd_sel_q     <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      kind_q       <= kind_d;
      len_q        <= len_d;
      data_left_q  <= data_left_d;
      wp_q         <= wp_d;
      name_start_q <= name_start_d;
      name_left_q  <= name_left_d;
      name_pos_q   <= name_pos_d;
      match_q      <= match_d;
      chk_q        <= chk_d;
      drain_q      <= drain_d;
      ovf_q        <= ovf_d;
      rec_cnt_q    <= rec_cnt_d;
      rep_cnt_q    <= rep_cnt_d;
      sweep_q      <= sweep_d;
      sweep_idx_q  <= sweep_idx_d;
      res_valid_q  <= res_valid_d;
      res_byte_q   <= res_byte_d;
      res_end_q    <= res_end_d;
      res_status_q <= res_status_d;
      rd_sel_q     <= rd_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= store_q[rd_addr];
  end

  assign result_valid_o         = res_valid_q;
  assign result_o.out_byte      = rd_sel_q ? rd_data_q : res_byte_q;
  assign result_o.record_end    = res_end_q;
  assign result_o.status        = res_status_q;
  assign result_o.record_count  = rec_cnt_q;
  assign result_o.replace_count = rep_cnt_q;

  `ORN_ASSERT_SAME(a_sweep_phase, sweep_q, phase_q == PH_DATA || phase_q == PH_SUM, "sweep outside data")
  `ORN_ASSERT_SAME(a_wp_bound, 1'b1, wp_q <= RB_P, "write pointer past buffer")
  `ORN_ASSERT_SAME(a_quiet_sweep, sweep_q, !res_valid_q, "result during sweep")
  `ORN_ASSERT_SAME(a_read_drain, rd_sel_q, res_valid_q && phase_q == PH_DRAIN, "stray buffer read")
  `ORN_ASSERT_NEXT(a_sweep_start, !sweep_q && sweep_d, sweep_q && sweep_idx_q == 5'd0, "bad sweep start")

endmodule

/* rtl/object_record_name_rewriter_unit.sv */
// Object-record name rewriter. Requests arrive on request_i and are taken at a
// rising edge with start high and busy low; op selects a stream byte, end of stream
// or a drain tick. Every record is held in an on-chip buffer of RECORD_BYTES bytes
// (one write port, one registered read port). One request is taken per cycle; the
// exception is a name in a type 0x96 record that matches the search name: after
// its last byte busy stays high while the buffer's single write port lays the
// replacement length byte and the replacement name bytes over the old name.
// A result shows on result_o for exactly one cycle, flagged by result_valid_o, in
// the cycle right after its request was taken; the receiver cannot hold it off, so
// it must sample every strobe. Drain ticks give one record byte each after the
// checksum byte is taken (type, length low, length high, data, then checksum with
// record_end set). No clearing pass: the buffer is only read where it was written.
// Configuration is an APB port with 64-bit data, registers at byte address 8*i;
// write it only while no record is in progress or being drained.
module object_record_name_rewriter_unit #(
  parameter int unsigned RECORD_BYTES = 4096,
  parameter int unsigned NAME_BYTES   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  orn_pkg::orn_req_t            request_i,
  // result channel
  output logic                         result_valid_o,
  output orn_pkg::orn_res_t            result_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [orn_pkg::PADDR_W-1:0]  paddr,
  input  logic [orn_pkg::PDATA_W-1:0]  pwdata,
  output logic [orn_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import orn_pkg::*;

  // search/replace names plus precomputed length and checksum deltas
  orn_cfg_t cfg;

  orn_cfg_regs #(
    .NAME_BYTES (NAME_BYTES)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // record parser, buffer, rewrite sweep and drain
  orn_core #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .request_i      (request_i),
    .cfg_i          (cfg),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

/* dv/testbench.sv */
// Record rewriter bench: object-file records stream in one request per accepted
// start, a shadow of the rewriter predicts every result strobe, and a checker
// compares each strobe field by field against the oldest prediction.
module testbench;
  import orn_pkg::*;

  localparam int unsigned RECORD_BYTES  = 4096;
  localparam int unsigned NAME_BYTES    = 16;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int unsigned STALL_LIMIT   = 2000;
  // a match holds busy with no strobe while the rewrite runs
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned ITEMS_PER_CFG = 200;
  localparam int unsigned MAX_REPORTS   = 40;

  // parser position of the shadow model
  typedef enum logic [2:0] {
    AWAIT_TYPE,
    AWAIT_LEN_LO,
    AWAIT_LEN_HI,
    IN_DATA,
    AWAIT_SUM,
    DRAINING
  } parse_e;

  typedef logic [7:0] octets_t[$];

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  orn_req_t            request_i;
  logic                result_valid_o;
  orn_res_t            result_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  object_record_name_rewriter_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .request_i      (request_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow rewriter: configuration copy, parser state and the record buffer.
  // ---------------------------------------------------------------------------
  logic [4:0]  srch_len = '0;
  logic [63:0] srch_lo  = '0;
  logic [63:0] srch_hi  = '0;
  logic [4:0]  repl_len = '0;
  logic [63:0] repl_lo  = '0;
  logic [63:0] repl_hi  = '0;

  parse_e      phase_q      = AWAIT_TYPE;
  logic [7:0]  kind_q       = '0;
  int unsigned len_field    = 0;
  int unsigned data_left    = 0;
  int unsigned wr_ptr       = 0;
  int unsigned nm_start     = 0;
  int unsigned nm_left      = 0;
  int unsigned nm_pos       = 0;
  bit          nm_match     = 1'b0;
  bit          ovf          = 1'b0;
  logic [7:0]  sum_q        = '0;
  int unsigned rd_ptr       = 0;
  int unsigned records_seen = 0;
  int unsigned renames_done = 0;
  logic [7:0]  record_mem [RECORD_BYTES];

  // strobes still owed by the block, oldest first
  orn_res_t    results_due[$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned stalled    = 0;
  bit          gaps_on    = 1'b1;

  // byte i of a name packed into two words, zero past the sixteenth
  function automatic logic [7:0] name_char(logic [63:0] lo, logic [63:0] hi, int unsigned i);
    if (i < 8) return lo[8*i +: 8];
    if (i < 16) return hi[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void store_byte(logic [7:0] b);
    if (ovf) return;
    if (wr_ptr >= RECORD_BYTES) begin
      ovf = 1'b1;
      return;
    end
    record_mem[wr_ptr] = b;
    wr_ptr++;
  endfunction

  // Overwrite a matched name in place; length and checksum move by the difference.
  function automatic void close_name();
    int unsigned rl;
    int unsigned corr;
    logic [7:0]  c;
    if (!nm_match) return;
    nm_match = 1'b0;
    rl = (repl_len > NAME_BYTES) ? NAME_BYTES : 32'(repl_len);
    if (nm_start + 1 + rl > RECORD_BYTES) begin
      ovf = 1'b1;
      return;
    end
    corr = rl - 32'(srch_len);
    record_mem[nm_start] = rl[7:0];
    for (int unsigned i = 0; i < rl; i++) begin
      c = name_char(repl_lo, repl_hi, i);
      record_mem[nm_start + 1 + i] = c;
      corr += 32'(c);
    end
    for (int unsigned i = 0; i < srch_len; i++) corr -= 32'(name_char(srch_lo, srch_hi, i));
    wr_ptr    = nm_start + 1 + rl;
    sum_q     = sum_q + corr[7:0];
    len_field = (len_field + rl - 32'(srch_len)) & 32'hFFFF;
    if (renames_done < 32'hFFFF) renames_done++;
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    if (nm_left == 0) begin
      // length byte of a new name
      nm_start = wr_ptr - 1;
      nm_pos   = 0;
      nm_match = (b == srch_len) && (srch_len <= NAME_BYTES);
      nm_left  = 32'(b);
      if (b == 8'h00) close_name();
      return;
    end
    if (nm_match) begin
      if (b != name_char(srch_lo, srch_hi, nm_pos)) nm_match = 1'b0;
      nm_pos++;
    end
    nm_left--;
    if (nm_left == 0) close_name();
  endfunction

  function automatic orn_res_t make_result(logic [7:0] value, logic last, status_e st);
    orn_res_t r;
    r.out_byte      = value;
    r.record_end    = last;
    r.status        = st;
    r.record_count  = records_seen[15:0];
    r.replace_count = renames_done[15:0];
    return r;
  endfunction

  // Advance the shadow by one accepted request and queue the strobe it owes.
  function automatic void rewrite_request(orn_req_t req);
    logic [7:0]  b;
    int unsigned i;
    status_e     st;
    b = req.in_byte;
    case (req.op)
      OP_BYTE: begin
        case (phase_q)
          AWAIT_TYPE: begin
            if (records_seen < 32'hFFFF) records_seen++;
            kind_q    = b;
            len_field = 0;
            wr_ptr    = 0;
            nm_left   = 0;
            nm_pos    = 0;
            nm_match  = 1'b0;
            sum_q     = '0;
            ovf       = 1'b0;
            phase_q   = AWAIT_LEN_LO;
          end
          AWAIT_LEN_LO: begin
            len_field = 32'(b);
            phase_q   = AWAIT_LEN_HI;
          end
          AWAIT_LEN_HI: begin
            len_field = {16'h0000, b, len_field[7:0]};
            data_left = (len_field > 0) ? len_field - 1 : 0;
            if (data_left > RECORD_BYTES) ovf = 1'b1;
            phase_q = (data_left != 0) ? IN_DATA : AWAIT_SUM;
          end
          IN_DATA: begin
            data_left--;
            store_byte(b);
            if (!ovf && kind_q == NAME_LIST_KIND) scan_byte(b);
            if (data_left == 0) phase_q = AWAIT_SUM;
          end
          AWAIT_SUM: begin
            sum_q = sum_q + b;
            if (ovf) begin
              // oversized record is dropped at its checksum
              ovf     = 1'b0;
              phase_q = AWAIT_TYPE;
              results_due.push_back(make_result(8'h00, 1'b0, ST_OVERFLOW));
            end else begin
              rd_ptr  = 0;
              phase_q = DRAINING;
            end
          end
          default: results_due.push_back(make_result(8'h00, 1'b0, ST_BUSY_DROP));
        endcase
      end
      OP_END: begin
        case (phase_q)
          AWAIT_LEN_LO, AWAIT_LEN_HI: st = ST_SHORT_LEN;
          IN_DATA:                    st = ST_SHORT_DATA;
          AWAIT_SUM:                  st = ST_SHORT_SUM;
          default:                    st = ST_CLEAN_END;
        endcase
        // a record being drained keeps draining
        if (phase_q != DRAINING) begin
          phase_q  = AWAIT_TYPE;
          ovf      = 1'b0;
          nm_left  = 0;
          nm_match = 1'b0;
        end
        results_due.push_back(make_result(8'h00, 1'b0, st));
      end
      OP_DRAIN: begin
        if (phase_q == DRAINING) begin
          i = rd_ptr;
          rd_ptr++;
          if (i == 0) begin
            results_due.push_back(make_result(kind_q, 1'b0, ST_BYTE));
          end else if (i == 1) begin
            results_due.push_back(make_result(len_field[7:0], 1'b0, ST_BYTE));
          end else if (i == 2) begin
            results_due.push_back(make_result(len_field[15:8], 1'b0, ST_BYTE));
          end else if (i - 3 < wr_ptr && i - 3 < RECORD_BYTES) begin
            results_due.push_back(make_result(record_mem[i-3], 1'b0, ST_BYTE));
          end else begin
            phase_q = AWAIT_TYPE;
            results_due.push_back(make_result(sum_q, 1'b1, ST_BYTE));
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: the block cannot be held off, so every strobe is taken.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    orn_res_t want;
    if (rst_ni && result_valid_o) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing expected, actual %p", $time, result_o);
      end else begin
        want = results_due.pop_front();
        check_field("out_byte", want.out_byte, result_o.out_byte);
        check_field("record_end", want.record_end, result_o.record_end);
        check_field("status", want.status, result_o.status);
        check_field("record_count", want.record_count, result_o.record_count);
        check_field("replace_count", want.replace_count, result_o.replace_count);
      end
    end
  end

  // Watchdog: any handshake, strobe or register access counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || psel) begin
      stalled = 0;
    end else begin
      stalled++;
      if (stalled >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Hold one request until taken, then maybe idle; start stays up between
  // back-to-back requests.
  task automatic send_request(logic [1:0] op, logic [7:0] value);
    orn_req_t    req;
    int unsigned pick;
    int unsigned gap;
    req.op      = op;
    req.in_byte = value;
    start     <= 1'b1;
    request_i <= req;
    do begin
      @(posedge clk_i);
    end while (busy);
    rewrite_request(req);
    items_sent++;
    pick = $urandom_range(0, 99);
    gap  = 0;
    if (gaps_on && pick < 25) gap = (pick < 21) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_header(logic [7:0] kind, logic [15:0] len);
    send_request(OP_BYTE, kind);
    send_request(OP_BYTE, len[7:0]);
    send_request(OP_BYTE, len[15:8]);
  endtask

  task automatic send_body(octets_t body);
    foreach (body[i]) send_request(OP_BYTE, body[i]);
  endtask

  // Drain ticks until the record is out; noise_pct mixes in dropped bytes,
  // end-of-stream markers and unused ops.
  task automatic drain_record(int unsigned noise_pct);
    int unsigned pick;
    while (phase_q == DRAINING) begin
      pick = $urandom_range(0, 99);
      if (pick < noise_pct) begin
        case (pick % 3)
          0:       send_request(OP_BYTE, rand_byte());
          1:       send_request(OP_END, rand_byte());
          default: send_request(OP_UNUSED, rand_byte());
        endcase
      end else begin
        send_request(OP_DRAIN, rand_byte());
      end
    end
  endtask

  // Let owed strobes and any rewrite in progress finish.
  task automatic quiesce();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup then access; the register updates on the access edge.
  task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 3;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SEARCH_LEN:   srch_len = value[4:0];
      REG_SEARCH_LOW:   srch_lo  = value;
      REG_SEARCH_HIGH:  srch_hi  = value;
      REG_REPLACE_LEN:  repl_len = value[4:0];
      REG_REPLACE_LOW:  repl_lo  = value;
      REG_REPLACE_HIGH: repl_hi  = value;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [4:0] sl, logic [63:0] slo, logic [63:0] shi,
                              logic [4:0] rl, logic [63:0] rlo, logic [63:0] rhi);
    quiesce();
    write_reg(REG_SEARCH_LEN, {59'd0, sl});
    write_reg(REG_SEARCH_LOW, slo);
    write_reg(REG_SEARCH_HIGH, shi);
    write_reg(REG_REPLACE_LEN, {59'd0, rl});
    write_reg(REG_REPLACE_LOW, rlo);
    write_reg(REG_REPLACE_HIGH, rhi);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // length byte plus the first n bytes of a packed name
  function automatic void push_name(ref octets_t body, input logic [63:0] lo,
                                    input logic [63:0] hi, input int unsigned n);
    body.push_back(n[7:0]);
    for (int unsigned i = 0; i < n; i++) body.push_back(name_char(lo, hi, i));
  endfunction

  function automatic void push_random_name(ref octets_t body, input int unsigned n);
    body.push_back(n[7:0]);
    for (int unsigned i = 0; i < n; i++) body.push_back(rand_byte());
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Unused op, idle drain, idle end; reset config rewrites empty names to
  // empty names; zero and one length records.
  task automatic test_idle_requests();
    send_request(OP_UNUSED, 8'hFF);
    send_request(OP_DRAIN, 8'h00);
    send_request(OP_END, 8'h00);
    send_header(NAME_LIST_KIND, 16'd3);
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'hFF);
    drain_record(0);
    send_header(8'h00, 16'd0);
    send_request(OP_BYTE, 8'h5A);
    drain_record(0);
    send_header(8'hFF, 16'd1);
    send_request(OP_BYTE, 8'h00);
    drain_record(0);
  endtask

  // End of stream inside each field of a record.
  task automatic test_truncated_records();
    send_request(OP_BYTE, 8'h80);
    send_request(OP_END, 8'h00);
    send_request(OP_BYTE, NAME_LIST_KIND);
    send_request(OP_BYTE, 8'h05);
    send_request(OP_END, 8'h00);
    send_header(NAME_LIST_KIND, 16'd4);
    send_request(OP_BYTE, 8'h02);
    send_request(OP_END, 8'h00);
    send_header(8'h88, 16'd1);
    send_request(OP_END, 8'h00);
    send_header(8'h01, 16'hFFFF);
    send_request(OP_END, 8'h00);
  endtask

  // Growing rewrite: hits, a near miss, a name cut by the record end, then
  // drops and end markers while draining; the same data in another record type.
  task automatic test_name_replace();
    octets_t body;
    apply_config(5'd3, rand_word(), rand_word(), 5'd6, rand_word(), rand_word());
    push_name(body, srch_lo, srch_hi, srch_len);
    push_random_name(body, 3);
    push_name(body, srch_lo, srch_hi, srch_len);
    body[body.size()-1] = body[body.size()-1] ^ 8'h80;
    push_name(body, srch_lo, srch_hi, srch_len);
    push_name(body, srch_lo, srch_hi, srch_len);
    void'(body.pop_back());
    send_header(NAME_LIST_KIND, 16'(body.size() + 1));
    send_body(body);
    send_request(OP_BYTE, 8'hC3);
    send_request(OP_DRAIN, 8'h00);
    send_request(OP_BYTE, 8'h33);
    send_request(OP_END, 8'h00);
    drain_record(0);
    send_header(8'h97, 16'(body.size() + 1));
    send_body(body);
    send_request(OP_BYTE, 8'h3C);
    drain_record(0);
  endtask

  // Full-length search, replacement above the name limit, search above the
  // limit, and empty names rewritten to full-length ones.
  task automatic test_name_limits();
    octets_t body;
    apply_config(5'd16, rand_word(), rand_word(), 5'd31, rand_word(), rand_word());
    push_name(body, srch_lo, srch_hi, srch_len);
    send_header(NAME_LIST_KIND, 16'(body.size() + 1));
    send_body(body);
    send_request(OP_BYTE, 8'h00);
    drain_record(0);
    body.delete();
    apply_config(5'd17, rand_word(), rand_word(), 5'd0, rand_word(), rand_word());
    push_name(body, srch_lo, srch_hi, srch_len);
    send_header(NAME_LIST_KIND, 16'(body.size() + 1));
    send_body(body);
    send_request(OP_BYTE, 8'hFF);
    drain_record(0);
    body.delete();
    apply_config(5'd0, rand_word(), rand_word(), 5'd16, rand_word(), rand_word());
    body.push_back(8'h00);
    body.push_back(8'h00);
    send_header(NAME_LIST_KIND, 16'(body.size() + 1));
    send_body(body);
    send_request(OP_BYTE, 8'h81);
    drain_record(0);
  endtask

  // Length field past the buffer: the record is flagged at once, takes no
  // part in scanning, and an end of stream inside its data drops it.
  task automatic test_oversized_records();
    send_header(NAME_LIST_KIND, 16'(RECORD_BYTES + 2));
    for (int unsigned i = 0; i < 8; i++) send_request(OP_BYTE, rand_byte());
    send_request(OP_END, 8'h00);
    send_header(8'h3C, 16'(RECORD_BYTES + 2));
    send_request(OP_BYTE, 8'h00);
    send_request(OP_END, 8'h00);
  endtask

  // One mostly well-formed record with random content; some are cut short.
  task automatic random_record();
    octets_t     body;
    octets_t     stream;
    int unsigned pick;
    int unsigned target;
    int unsigned idx;
    int unsigned stop;
    logic [7:0]  kind;
    logic [15:0] len;
    gaps_on = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // stray request between records
      case (pick % 3)
        0:       send_request(OP_DRAIN, rand_byte());
        1:       send_request(OP_END, rand_byte());
        default: send_request(OP_UNUSED, rand_byte());
      endcase
    end
    kind = ($urandom_range(0, 9) < 8) ? NAME_LIST_KIND : rand_byte();
    target = $urandom_range(0, 28);
    while (body.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_name(body, srch_lo, srch_hi, srch_len);
      end else if (pick < 55) begin
        // near miss: one bit off in a name byte or in its length byte
        push_name(body, srch_lo, srch_hi, srch_len);
        idx = body.size() - 1 - $urandom_range(0, srch_len);
        body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
      end else begin
        push_random_name(body, $urandom_range(0, 20));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) if (body.size() != 0) void'(body.pop_back());
    end
    len = 16'(body.size() + 1);
    if (body.size() == 0 && $urandom_range(0, 1) == 0) len = 16'd0;
    stream.push_back(kind);
    stream.push_back(len[7:0]);
    stream.push_back(len[15:8]);
    foreach (body[i]) stream.push_back(body[i]);
    stream.push_back(rand_byte());
    if ($urandom_range(0, 9) == 0) begin
      stop = $urandom_range(1, stream.size() - 1);
      for (int unsigned i = 0; i < stop; i++) send_request(OP_BYTE, stream[i]);
      send_request(OP_END, rand_byte());
    end else begin
      send_body(stream);
      drain_record(6);
    end
  endtask

  // Several settings, extremes first: empty search, full length, long
  // replacement cut to the limit, and a search that can never match.
  task automatic test_random_streams();
    int unsigned goal;
    logic [4:0]  sl;
    logic [4:0]  rl;
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: begin
          sl = 5'd0;
          rl = 5'd16;
        end
        1: begin
          sl = 5'd16;
          rl = 5'd31;
        end
        2: begin
          sl = 5'($urandom_range(1, 8));
          rl = 5'($urandom_range(0, 16));
        end
        3: begin
          sl = 5'($urandom_range(1, 16));
          rl = 5'($urandom_range(17, 31));
        end
        default: begin
          sl = 5'($urandom_range(17, 31));
          rl = 5'($urandom_range(0, 16));
        end
      endcase
      apply_config(sl, rand_word(), rand_word(), rl, rand_word(), rand_word());
      goal = items_sent + ITEMS_PER_CFG;
      while (items_sent < goal) random_record();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    start     <= 1'b0;
    request_i <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    rst_ni    <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_requests();
    test_truncated_records();
    test_name_replace();
    test_name_limits();
    test_oversized_records();
    test_random_streams();
    quiesce();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/orn_pkg.sv
rtl/orn_cfg_regs.sv
rtl/orn_core.sv
rtl/object_record_name_rewriter_unit.sv
dv/testbench.sv
